// File: rtl/triangle_barycentric_coords_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the triangle barycentric coordinates block
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_BARYCENTRIC_COORDS_TOP_ASSERT_SVH
`define TRIANGLE_BARYCENTRIC_COORDS_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TBC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TBC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TBC_ASSERT_IMP(lbl, ante, cons)
`define TBC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: rtl/tbc_pkg.sv
// ----------------------------------------------------------------------------
// tbc_pkg
// Shared types and register indexes of the barycentric coordinates block.
// ----------------------------------------------------------------------------
`default_nettype none
package tbc_pkg;

  localparam int REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_A_X = 3'd0,
    REG_A_Y = 3'd1,
    REG_B_X = 3'd2,
    REG_B_Y = 3'd3,
    REG_C_X = 3'd4,
    REG_C_Y = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic sat;
  } div_flags_t;

endpackage
`default_nettype wire

// File: rtl/tbc_divider.sv
// ----------------------------------------------------------------------------
// tbc_divider
// Pipelined signed divider: round(num * 2^F / den), ties away from zero,
// clamped to a signed (F+5)-bit code. One quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module tbc_divider #(
  parameter int NUM_WIDTH = 37,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic signed [NUM_WIDTH-1:0]  num,
  input  wire logic signed [NUM_WIDTH-1:0]  den,
  output logic signed [FRAC_BITS+4:0]       weight,
  output tbc_pkg::div_flags_t               flags
);
  import tbc_pkg::*;

  localparam int WW   = FRAC_BITS + 5;
  localparam int QW   = WW + 1;
  localparam int CMPW = NUM_WIDTH + WW + 3;
  localparam int DDW  = NUM_WIDTH + 1;
  localparam int NS   = QW;

  // magnitudes
  logic [NUM_WIDTH-1:0] mag_a;
  logic [NUM_WIDTH-1:0] mag_b;
  logic                 neg_a;

  always_ff @(posedge clk) begin
    if (en) begin
      mag_a <= num[NUM_WIDTH-1] ? NUM_WIDTH'(-num) : NUM_WIDTH'(num);
      mag_b <= den[NUM_WIDTH-1] ? NUM_WIDTH'(-den) : NUM_WIDTH'(den);
      neg_a <= num[NUM_WIDTH-1] ^ den[NUM_WIDTH-1];
    end
  end

  // n = 2a*2^F + b, d = 2b; quotient of n/d is the rounded result
  logic [CMPW-1:0] n_c;
  logic [CMPW-1:0] d_c;
  logic            ovf_c;

  assign n_c   = (CMPW'(mag_a) << (FRAC_BITS + 1)) + CMPW'(mag_b);
  assign d_c   = CMPW'(mag_b) << 1;
  assign ovf_c = n_c >= (d_c << QW);

  logic [CMPW-1:0] rem_s [0:NS-1];
  logic [DDW-1:0]  dd_s  [0:NS-1];
  logic            neg_s [0:NS];
  logic            ovf_s [0:NS];
  logic [QW-1:0]   q_s   [1:NS];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0] <= n_c;
      dd_s[0]  <= d_c[DDW-1:0];
      neg_s[0] <= neg_a;
      ovf_s[0] <= ovf_c;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_bit
    localparam int SH = QW - 1 - k;
    logic [CMPW-1:0] sub;
    logic            ge;
    logic [QW-1:0]   q_prev;

    if (k == 0) begin : g_first
      assign q_prev = '0;
    end else begin : g_rest
      assign q_prev = q_s[k];
    end

    assign sub = CMPW'(dd_s[k]) << SH;
    assign ge  = rem_s[k] >= sub;

    always_ff @(posedge clk) begin
      if (en) begin
        neg_s[k+1] <= neg_s[k];
        ovf_s[k+1] <= ovf_s[k];
        q_s[k+1]   <= {q_prev[QW-2:0], ge};
      end
    end

    // the last stage needs no remainder or divisor downstream
    if (k < NS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_s[k+1] <= ge ? rem_s[k] - sub : rem_s[k];
          dd_s[k+1]  <= dd_s[k];
        end
      end
    end
  end

  // clamp and apply sign
  logic [QW-1:0] lim;
  logic [QW-1:0] qm;
  logic [QW-1:0] res;
  logic          sat;

  assign lim = neg_s[NS] ? (QW'(1) << (WW - 1)) : ((QW'(1) << (WW - 1)) - QW'(1));
  assign sat = ovf_s[NS] | (q_s[NS] > lim);
  assign qm  = sat ? lim : q_s[NS];
  assign res = neg_s[NS] ? QW'(-qm) : qm;

  assign weight    = res[WW-1:0];
  assign flags.sat = sat;

endmodule
`default_nettype wire

// File: rtl/triangle_barycentric_coords_top.sv
// Barycentric weights of a point against a triangle held in six Q8.8 vertex
// registers. One point request is taken every clock cycle while a valid
// output is not stalled. Each result passes through the edge-difference,
// product and cross-term stages, then the divider (two setup stages and one
// stage per quotient bit, WEIGHT_FRAC_BITS + 6 bits), then the output
// register. A stall on a valid output freezes the whole pipeline, so in_stall
// follows it in the same cycle.
// ----------------------------------------------------------------------------
// triangle_barycentric_coords_top
// Per-point u, v, w weights in signed Q4.16 with saturation and a
// degenerate-triangle flag.
// ----------------------------------------------------------------------------
`default_nettype none
`include "triangle_barycentric_coords_top_assert.svh"
module triangle_barycentric_coords_top #(
  parameter int COORD_WIDTH      = 16,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [tbc_pkg::REG_IDX_W-1:0]      cfg_index,
  input  wire logic [COORD_WIDTH-1:0]             cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [COORD_WIDTH-1:0]      point_x,
  input  wire logic signed [COORD_WIDTH-1:0]      point_y,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [WEIGHT_FRAC_BITS+4:0]      weight_u,
  output logic signed [WEIGHT_FRAC_BITS+4:0]      weight_v,
  output logic signed [WEIGHT_FRAC_BITS+4:0]      weight_w,
  output logic                                    degenerate,
  output logic                                    saturated
);
  import tbc_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int DW  = CW + 1;
  localparam int PW  = 2 * DW;
  localparam int NW  = 2 * CW + 5;
  localparam int WW  = WEIGHT_FRAC_BITS + 5;
  localparam int DL  = WW + 3;
  localparam int LAT = DL + 3;

  // vertex registers
  logic signed [CW-1:0] va_x, va_y, vb_x, vb_y, vc_x, vc_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      va_x <= '0;
      va_y <= '0;
      vb_x <= '0;
      vb_y <= '0;
      vc_x <= '0;
      vc_y <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_A_X: va_x <= cfg_data;
        REG_A_Y: va_y <= cfg_data;
        REG_B_X: vb_x <= cfg_data;
        REG_B_Y: vb_y <= cfg_data;
        REG_C_X: vc_x <= cfg_data;
        REG_C_Y: vc_y <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: edge vectors from vertex a
  logic signed [DW-1:0] abx, aby, acx, acy, apx, apy;

  always_ff @(posedge clk) begin
    if (en) begin
      abx <= DW'(vb_x) - DW'(va_x);
      aby <= DW'(vb_y) - DW'(va_y);
      acx <= DW'(vc_x) - DW'(va_x);
      acy <= DW'(vc_y) - DW'(va_y);
      apx <= DW'(point_x) - DW'(va_x);
      apy <= DW'(point_y) - DW'(va_y);
    end
  end

  // stage 2: six products
  logic signed [PW-1:0] pd1, pd2, pu1, pu2, pv1, pv2;

  always_ff @(posedge clk) begin
    if (en) begin
      pd1 <= abx * acy;
      pd2 <= acx * aby;
      pu1 <= apx * acy;
      pu2 <= acx * apy;
      pv1 <= abx * apy;
      pv2 <= apx * aby;
    end
  end

  // stage 3: cross terms and w numerator
  logic signed [NW-1:0] den_c, nu_c, nv_c;
  logic signed [NW-1:0] den_r, nu_r, nv_r, nw_r;

  assign den_c = NW'(pd1) - NW'(pd2);
  assign nu_c  = NW'(pu1) - NW'(pu2);
  assign nv_c  = NW'(pv1) - NW'(pv2);

  logic dgn [0:DL];

  always_ff @(posedge clk) begin
    if (en) begin
      den_r  <= den_c;
      nu_r   <= nu_c;
      nv_r   <= nv_c;
      nw_r   <= den_c - nu_c - nv_c;
      dgn[0] <= den_c == '0;
    end
  end

  for (genvar j = 1; j <= DL; j++) begin : g_dgn
    always_ff @(posedge clk) begin
      if (en) begin
        dgn[j] <= dgn[j-1];
      end
    end
  end

  logic signed [WW-1:0] wu_c, wv_c, ww_c;
  div_flags_t           fu, fv, fw;

  tbc_divider #(.NUM_WIDTH(NW), .FRAC_BITS(WEIGHT_FRAC_BITS)) u_div_u (
    .clk(clk), .en(en), .num(nu_r), .den(den_r), .weight(wu_c), .flags(fu)
  );

  tbc_divider #(.NUM_WIDTH(NW), .FRAC_BITS(WEIGHT_FRAC_BITS)) u_div_v (
    .clk(clk), .en(en), .num(nv_r), .den(den_r), .weight(wv_c), .flags(fv)
  );

  tbc_divider #(.NUM_WIDTH(NW), .FRAC_BITS(WEIGHT_FRAC_BITS)) u_div_w (
    .clk(clk), .en(en), .num(nw_r), .den(den_r), .weight(ww_c), .flags(fw)
  );

  // valid bits alongside the data
  logic vld [0:LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  for (genvar j = 1; j < LAT; j++) begin : g_vld
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= vld[j-1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dgn[DL]) begin
        weight_u  <= '0;
        weight_v  <= '0;
        weight_w  <= '0;
        saturated <= 1'b0;
      end else begin
        weight_u  <= wu_c;
        weight_v  <= wv_c;
        weight_w  <= ww_c;
        saturated <= fu.sat | fv.sat | fw.sat;
      end
      degenerate <= dgn[DL];
    end
  end

  `TBC_ASSERT_IMP(a_degen_zero, out_valid && degenerate,
                  weight_u == '0 && weight_v == '0 && weight_w == '0 && !saturated)
  `TBC_ASSERT_NXT(a_in_enters, in_valid && !in_stall, vld[0])
  `TBC_ASSERT_NXT(a_last_to_out, vld[LAT-1] && en, out_valid)

endmodule
`default_nettype wire

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// Barycentric weights testbench
// Loads triangles through the vertex registers, sends query points under
// several idle and stall patterns, and checks u, v, w and flags against an
// exact integer prediction.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
  import tbc_pkg::*;

  localparam int CW = 16;
  localparam int FB = 16;
  localparam int WW = FB + 5;
  localparam int LATENCY = FB + 12;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
  } point_req_t;

  typedef struct packed {
    logic [WW-1:0] u;
    logic [WW-1:0] v;
    logic [WW-1:0] w;
    logic          degen;
    logic          sat;
  } weights_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] point_x = '0;
  logic signed [CW-1:0] point_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [WW-1:0] weight_u, weight_v, weight_w;
  logic degenerate, saturated;

  triangle_barycentric_coords_top u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .point_x(point_x), .point_y(point_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .weight_u(weight_u), .weight_v(weight_v), .weight_w(weight_w),
    .degenerate(degenerate), .saturated(saturated)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic signed [CW-1:0] vtx [6];
  point_req_t pending_points[$];
  weights_t   expected_weights[$];
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_off = 1'b0;
  bit in_fire = 1'b0;
  int mismatches = 0;
  int results_seen = 0;
  int sat_seen = 0;
  int degen_seen = 0;
  longint cycles = 0;

  // round(num * 2^FB / den), ties away from zero, clamped to WW bits
  function automatic logic [WW-1:0] divide_weight(logic signed [63:0] num,
                                                  logic signed [63:0] den,
                                                  inout bit sat);
    logic [127:0] mag_n, mag_d, q;
    logic [63:0] lim;
    bit neg;
    neg = (num < 0) != (den < 0);
    mag_n = num < 0 ? -num : num;
    mag_d = den < 0 ? -den : den;
    q = ((mag_n << (FB + 1)) + mag_d) / (mag_d << 1);
    lim = neg ? (64'd1 << (WW - 1)) : (64'd1 << (WW - 1)) - 1;
    if (q > lim) begin
      sat = 1'b1;
      q = lim;
    end
    if (neg) q = -q;
    return q[WW-1:0];
  endfunction

  function automatic weights_t predict_weights(point_req_t p);
    logic signed [63:0] abx, aby, acx, acy, apx, apy, d, nu, nv;
    weights_t r;
    bit sat;
    abx = vtx[REG_B_X] - vtx[REG_A_X];
    aby = vtx[REG_B_Y] - vtx[REG_A_Y];
    acx = vtx[REG_C_X] - vtx[REG_A_X];
    acy = vtx[REG_C_Y] - vtx[REG_A_Y];
    apx = p.px - vtx[REG_A_X];
    apy = p.py - vtx[REG_A_Y];
    d  = abx * acy - acx * aby;
    nu = apx * acy - acx * apy;
    nv = abx * apy - apx * aby;
    r = '0;
    sat = 1'b0;
    if (d == 0) begin
      r.degen = 1'b1;
      return r;
    end
    r.u = divide_weight(nu, d, sat);
    r.v = divide_weight(nv, d, sat);
    r.w = divide_weight(d - nu - nv, d, sat);
    r.sat = sat;
    return r;
  endfunction

  // driver: move on only once the current request was taken at the last edge
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_fire)) begin
      if (pending_points.size() > 0 && $urandom_range(99) >= idle_pct) begin
        point_req_t p;
        p = pending_points.pop_front();
        point_x <= p.px;
        point_y <= p.py;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  // input monitor: predict at acceptance
  always @(posedge clk) begin
    in_fire <= in_valid && !in_stall;
    if (!rst && in_valid && !in_stall)
      expected_weights.push_back(predict_weights('{px: point_x, py: point_y}));
  end

  // output monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      weights_t got, exp_w;
      got = '{u: weight_u, v: weight_v, w: weight_w, degen: degenerate,
              sat: saturated};
      results_seen <= results_seen + 1;
      if (expected_weights.size() == 0) begin
        if (mismatches < 10) $display("unexpected result %p", got);
        mismatches <= mismatches + 1;
      end else begin
        exp_w = expected_weights.pop_front();
        if (exp_w.sat) sat_seen <= sat_seen + 1;
        if (exp_w.degen) degen_seen <= degen_seen + 1;
        if (got !== exp_w) begin
          if (mismatches < 10)
            $display("mismatch: exp u=%h v=%h w=%h dg=%b st=%b got u=%h v=%h w=%h dg=%b st=%b",
                     exp_w.u, exp_w.v, exp_w.w, exp_w.degen, exp_w.sat,
                     got.u, got.v, got.w, got.degen, got.sat);
          mismatches <= mismatches + 1;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_vertex(reg_idx_t idx, logic [CW-1:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx <= REG_C_Y) vtx[idx] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_triangle(logic [CW-1:0] ax, ay, bx, by, cx, cy);
    write_vertex(REG_A_X, ax);
    write_vertex(REG_A_Y, ay);
    write_vertex(REG_B_X, bx);
    write_vertex(REG_B_Y, by);
    write_vertex(REG_C_X, cx);
    write_vertex(REG_C_Y, cy);
  endtask

  task automatic drain();
    while (pending_points.size() > 0 || in_valid || expected_weights.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [CW-1:0] rand_coord(int mode);
    case (mode)
      0: return CW'($urandom);
      1: return CW'($urandom_range(2048) - 1024);
      default: return CW'($urandom_range(255) - 128);
    endcase
  endfunction

  task automatic random_points(int n, int mode);
    repeat (n) pending_points.push_back('{px: rand_coord(mode), py: rand_coord(mode)});
  endtask

  task automatic random_triangle(int mode);
    load_triangle(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                  rand_coord(mode), rand_coord(mode), rand_coord(mode));
  endtask

  initial begin
    foreach (vtx[i]) vtx[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset state: all vertices zero, so degenerate
    pending_points.push_back('{px: 16'sh7fff, py: -16'sh8000});
    drain();

    // unit right triangle, corners, centroid, far-out points, extremes
    load_triangle(16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h0100);
    pending_points.push_back('{px: 16'h0000, py: 16'h0000});
    pending_points.push_back('{px: 16'h0100, py: 16'h0000});
    pending_points.push_back('{px: 16'h0000, py: 16'h0100});
    pending_points.push_back('{px: 16'h0055, py: 16'h0055});
    pending_points.push_back('{px: 16'h0080, py: 16'h0080});
    pending_points.push_back('{px: 16'h7fff, py: 16'h7fff});
    pending_points.push_back('{px: 16'h8000, py: 16'h8000});
    pending_points.push_back('{px: 16'h7fff, py: 16'h8000});
    pending_points.push_back('{px: 16'hffff, py: 16'h0001});
    drain();

    // extreme triangle
    load_triangle(16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    pending_points.push_back('{px: 16'h0000, py: 16'h0000});
    pending_points.push_back('{px: 16'h7fff, py: 16'h7fff});
    pending_points.push_back('{px: 16'h8000, py: 16'h8000});
    pending_points.push_back('{px: 16'haaaa, py: 16'h5555});
    drain();

    // collinear vertices: degenerate
    load_triangle(16'h0100, 16'h0100, 16'h0200, 16'h0200, 16'h0300, 16'h0300);
    pending_points.push_back('{px: 16'h0150, py: 16'h0000});
    drain();

    // tiny triangle: one of its two points saturates; also an ignored register index
    load_triangle(16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0001);
    write_vertex(reg_idx_t'(3'd7), 16'h1234);
    pending_points.push_back('{px: 16'h0010, py: 16'hfff0});
    pending_points.push_back('{px: 16'h0000, py: 16'h0001});
    drain();

    // random phases under varied idle and stall
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 88; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 88; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      random_triangle(ph % 3);
      if (ph == 5) write_vertex(REG_C_X, vtx[REG_A_X]);
      if (ph == 5) write_vertex(REG_C_Y, vtx[REG_A_Y]);
      if (ph == 0) begin
        hold_off = 1'b1;
        random_points(70, 2);
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        random_points(80, ph % 3);
      end
      drain();
    end

    $display("checked %0d results over several triangles and idle patterns", results_seen);
    $display("%0d saturated, %0d degenerate, %0d mismatches", sat_seen, degen_seen,
             mismatches);
    if (mismatches == 0 && expected_weights.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
